[hdl/nsp_pkg.sv]
// ----------------------------------------------------------------------------
// nsp_pkg
// Shared types and constants of the network information table section parser.
// ----------------------------------------------------------------------------
package nsp_pkg;

   localparam int NSP_MAX_PAYLOAD_BYTES = 4096;
   localparam int NSP_PLEN_W            = 13;
   localparam int NSP_QUEUE_DEPTH       = 4;

   // parse phases, one section at a time
   typedef enum logic [3:0] {
      PH_IDLE     = 4'd0,
      PH_NLEN     = 4'd1,
      PH_NET      = 4'd2,
      PH_NET_DLEN = 4'd3,
      PH_TLEN     = 4'd4,
      PH_EDESC    = 4'd5,
      PH_ENTRY    = 4'd6,
      PH_EDLEN    = 4'd7,
      PH_DONE     = 4'd8
   } phase_type;

   typedef enum logic [2:0] {
      KIND_NET_HDR   = 3'd0,
      KIND_NET_BYTE  = 3'd1,
      KIND_ENTRY     = 3'd2,
      KIND_STRM_HDR  = 3'd3,
      KIND_STRM_BYTE = 3'd4,
      KIND_SECT_END  = 3'd5
   } kind_type;

   // one classified byte: an optional main result and an optional section end
   typedef struct packed {
      logic        has_main;
      logic        with_end;
      kind_type    kind;
      logic [7:0]  tag;
      logic [7:0]  len;
      logic [7:0]  body;
      logic [15:0] sid;
      logic [15:0] nid;
   } evt_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_stat_type;

endpackage

[hdl/nit_section_parser_core.sv]
// ----------------------------------------------------------------------------
// nit_section_parser_core
// Streaming parser for network information table section payloads.
// ----------------------------------------------------------------------------
// Usage:
//   req_* takes one payload byte per word, req_first_byte on the first byte
//   of a section and req_payload_length steady through it. rsp_* gives the
//   decoded words: descriptor headers and bytes, stream entries and a
//   section end mark; rsp_last_of_run closes the words of one input byte.
//   Both sides are valid/ready.
// Path: a result event is written into the event queue when its byte is
//   taken and then moves into the output register, which presents it.
// Throughput: one byte per cycle while the event queue is not full. The
//   classifier updates its loop state for each byte it takes; a byte giving
//   two words (the last byte of a section) occupies the output register for
//   both words, and the 4-deep event queue absorbs that.
// Stall: when rsp_ready is low the queue fills and req_ready drops while it
//   holds four events, whether or not the waiting byte would give a word.
// Reset: synchronous; the parser waits for a word with req_first_byte and
//   the queue and output register are emptied.
// ----------------------------------------------------------------------------
module nit_section_parser_core
   import nsp_pkg::*;
#(
   parameter int MAX_PAYLOAD_BYTES = NSP_MAX_PAYLOAD_BYTES
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [7:0]            req_data_byte,
   input  logic                  req_first_byte,
   input  logic [NSP_PLEN_W-1:0] req_payload_length,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [2:0]            rsp_kind,
   output logic [7:0]            rsp_descriptor_tag,
   output logic [7:0]            rsp_descriptor_length,
   output logic [7:0]            rsp_body_byte,
   output logic [15:0]           rsp_stream_id,
   output logic [15:0]           rsp_network_id,
   output logic                  rsp_last_of_run
);

   queue_stat_type q_stat;
   logic           push, pop;
   evt_type        push_evt, head_evt;

   nsp_front #(
      .MAX_PAYLOAD_BYTES(MAX_PAYLOAD_BYTES)
   ) u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_data_byte      (req_data_byte),
      .req_first_byte     (req_first_byte),
      .req_payload_length (req_payload_length),
      .q_stat             (q_stat),
      .push               (push),
      .push_evt           (push_evt)
   );

   nsp_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_evt (push_evt),
      .pop      (pop),
      .head_evt (head_evt),
      .stat     (q_stat)
   );

   nsp_back u_back (
      .clock                 (clock),
      .reset                 (reset),
      .head_evt              (head_evt),
      .q_stat                (q_stat),
      .pop                   (pop),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_kind              (rsp_kind),
      .rsp_descriptor_tag    (rsp_descriptor_tag),
      .rsp_descriptor_length (rsp_descriptor_length),
      .rsp_body_byte         (rsp_body_byte),
      .rsp_stream_id         (rsp_stream_id),
      .rsp_network_id        (rsp_network_id),
      .rsp_last_of_run       (rsp_last_of_run)
   );

endmodule

[hdl/nsp_queue.sv]
// ----------------------------------------------------------------------------
// nsp_queue
// Short event queue between the byte classifier and the result sequencer.
// ----------------------------------------------------------------------------
module nsp_queue
   import nsp_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  evt_type        push_evt,
   input  logic           pop,
   output evt_type        head_evt,
   output queue_stat_type stat
);

   localparam int PTR_W = $clog2(NSP_QUEUE_DEPTH);
   localparam int CNT_W = $clog2(NSP_QUEUE_DEPTH + 1);

   evt_type            store_ff [NSP_QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + CNT_W'(push) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_evt;
      end
   end

   assign head_evt   = store_ff[rd_ptr_ff];
   assign stat.full  = (count_ff == CNT_W'(NSP_QUEUE_DEPTH));
   assign stat.empty = (count_ff == '0);

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(NSP_QUEUE_DEPTH))
      else $error("event queue count beyond depth");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && stat.full))
      else $error("push into full event queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !stat.empty)
      else $error("pop from empty event queue");

endmodule

[hdl/nsp_front.sv]
// ----------------------------------------------------------------------------
// nsp_front
// Byte classifier: walks the descriptor and stream loops one byte per word.
// ----------------------------------------------------------------------------
module nsp_front
   import nsp_pkg::*;
#(
   parameter int MAX_PAYLOAD_BYTES = NSP_MAX_PAYLOAD_BYTES
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [7:0]            req_data_byte,
   input  logic                  req_first_byte,
   input  logic [NSP_PLEN_W-1:0] req_payload_length,
   input  queue_stat_type        q_stat,
   output logic                  push,
   output evt_type               push_evt
);

   // largest usable length, and room for a loop end up to 4096 past it
   localparam int CAP   = (MAX_PAYLOAD_BYTES < 8191) ? MAX_PAYLOAD_BYTES : 8191;
   localparam int OFF_W = $clog2(CAP + 4097);

   phase_type          phase_ff, phase_in, phase_v;
   logic [OFF_W-1:0]   off_ff, off_in, off_v;
   logic [OFF_W-1:0]   net_end_ff, net_end_in;
   logic [OFF_W-1:0]   strm_end_ff, strm_end_in;
   logic [OFF_W-1:0]   edesc_end_ff, edesc_end_in;
   logic [OFF_W-1:0]   nhdr_ff, nhdr_in;
   logic [7:0]         tag_ff, tag_in;
   logic [7:0]         len_ff, len_in;
   logic [15:0]        sid_ff, sid_in;
   logic [15:0]        nid_ff, nid_in;
   logic               body_ok_ff, body_ok_in, body_v;

   logic               accept;
   logic [OFF_W-1:0]   plen_c, off_p1, b_ext, nib, dlen_end, k, edesc_new;
   logic               active, in_range, at_net_end, at_hdr, before_hdr;
   logic               net_fits, ed_fits, st_fits, last_byte;

   assign req_ready = !q_stat.full;
   assign accept    = req_valid && req_ready;

   assign plen_c = (OFF_W'(req_payload_length) > OFF_W'(CAP)) ? OFF_W'(CAP)
                                                             : OFF_W'(req_payload_length);
   assign phase_v = req_first_byte ? PH_NLEN : phase_ff;
   assign off_v   = req_first_byte ? '0 : off_ff;
   assign body_v  = req_first_byte ? 1'b0 : body_ok_ff;

   assign active     = (phase_v != PH_IDLE);
   assign in_range   = (off_v < plen_c);
   assign off_p1     = off_v + OFF_W'(1);
   assign b_ext      = OFF_W'(req_data_byte);
   assign nib        = OFF_W'(req_data_byte[3:0]) << 8;
   assign dlen_end   = off_p1 + b_ext;
   assign k          = off_v - nhdr_ff;
   assign at_net_end = (off_v == net_end_ff);
   assign at_hdr     = (off_v == nhdr_ff);
   assign before_hdr = (off_v < nhdr_ff);
   assign net_fits   = (off_v + OFF_W'(2) <= net_end_ff);
   assign ed_fits    = (off_v + OFF_W'(2) <= edesc_end_ff);
   assign st_fits    = (off_v + OFF_W'(2) <= strm_end_ff);
   assign last_byte  = (off_p1 == plen_c);
   assign edesc_new  = off_p1 + (edesc_end_ff | b_ext);

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (active) begin
         if (!in_range) begin
            phase_in = PH_IDLE;
         end else begin
            phase_in = phase_v;
            unique case (phase_v)
               PH_NLEN: begin
                  if (off_v != '0) phase_in = PH_NET;
               end
               PH_NET: begin
                  if (at_net_end) phase_in = PH_TLEN;
                  else if (at_hdr && net_fits) phase_in = PH_NET_DLEN;
               end
               PH_NET_DLEN: phase_in = PH_NET;
               PH_TLEN:     phase_in = PH_EDESC;
               PH_EDESC: begin
                  if (at_hdr) begin
                     if (ed_fits) phase_in = PH_EDLEN;
                     else if (st_fits) phase_in = PH_ENTRY;
                     else phase_in = PH_DONE;
                  end
               end
               PH_ENTRY: begin
                  if (k != OFF_W'(1) && k != OFF_W'(2) && k != OFF_W'(3) &&
                      k != OFF_W'(4)) phase_in = PH_EDESC;
               end
               PH_EDLEN: phase_in = PH_EDESC;
               default:  phase_in = phase_v;
            endcase
            if (last_byte) phase_in = PH_IDLE;
         end
      end
   end

   // datapath and event
   always_comb begin
      off_in       = off_ff;
      net_end_in   = net_end_ff;
      strm_end_in  = strm_end_ff;
      edesc_end_in = edesc_end_ff;
      nhdr_in      = nhdr_ff;
      tag_in       = tag_ff;
      len_in       = len_ff;
      sid_in       = sid_ff;
      nid_in       = nid_ff;
      body_ok_in   = body_ok_ff;
      push_evt          = '0;
      push_evt.kind     = KIND_NET_HDR;
      if (active) begin
         off_in     = off_v;
         body_ok_in = body_v;
         if (in_range) begin
            unique case (phase_v)
               PH_NLEN: begin
                  if (off_v == '0) begin
                     net_end_in = nib;
                  end else begin
                     net_end_in = OFF_W'(2) + (net_end_ff | b_ext);
                     nhdr_in    = OFF_W'(2);
                     body_ok_in = 1'b0;
                  end
               end
               PH_NET: begin
                  if (at_net_end) begin
                     strm_end_in = nib;
                  end else if (at_hdr) begin
                     body_ok_in = 1'b0;
                     if (net_fits) tag_in = req_data_byte;
                  end else if (before_hdr && body_v) begin
                     push_evt.has_main = 1'b1;
                     push_evt.kind     = KIND_NET_BYTE;
                  end
               end
               PH_NET_DLEN: begin
                  len_in     = req_data_byte;
                  nhdr_in    = dlen_end;
                  body_ok_in = (dlen_end <= net_end_ff);
                  if (dlen_end <= net_end_ff) begin
                     push_evt.has_main = 1'b1;
                     push_evt.kind     = KIND_NET_HDR;
                  end
               end
               PH_TLEN: begin
                  strm_end_in  = off_p1 + (strm_end_ff | b_ext);
                  nhdr_in      = off_p1;
                  edesc_end_in = '0;
                  body_ok_in   = 1'b0;
               end
               PH_EDESC: begin
                  if (at_hdr) begin
                     body_ok_in = 1'b0;
                     if (ed_fits) tag_in = req_data_byte;
                     else if (st_fits) sid_in = {req_data_byte, 8'h00};
                  end else if (before_hdr && body_v) begin
                     push_evt.has_main = 1'b1;
                     push_evt.kind     = KIND_STRM_BYTE;
                  end
               end
               PH_ENTRY: begin
                  if (k == OFF_W'(1)) begin
                     sid_in = {sid_ff[15:8], req_data_byte};
                  end else if (k == OFF_W'(2)) begin
                     nid_in = {req_data_byte, 8'h00};
                  end else if (k == OFF_W'(3)) begin
                     nid_in = {nid_ff[15:8], req_data_byte};
                  end else if (k == OFF_W'(4)) begin
                     edesc_end_in = nib;
                  end else begin
                     // entry descriptor loop never reaches past the payload
                     edesc_end_in = (edesc_new > plen_c) ? plen_c : edesc_new;
                     nhdr_in      = off_p1;
                     push_evt.has_main = 1'b1;
                     push_evt.kind     = KIND_ENTRY;
                  end
               end
               PH_EDLEN: begin
                  len_in     = req_data_byte;
                  nhdr_in    = dlen_end;
                  body_ok_in = (dlen_end <= edesc_end_ff);
                  if (dlen_end <= edesc_end_ff) begin
                     push_evt.has_main = 1'b1;
                     push_evt.kind     = KIND_STRM_HDR;
                  end
               end
               default: begin
               end
            endcase
            off_in = off_p1;
            if (last_byte) begin
               push_evt.with_end = 1'b1;
               body_ok_in        = 1'b0;
            end
         end
      end
      push_evt.tag  = tag_in;
      push_evt.len  = len_in;
      push_evt.body = req_data_byte;
      push_evt.sid  = sid_in;
      push_evt.nid  = nid_in;
   end

   assign push = accept && (push_evt.has_main || push_evt.with_end);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         off_ff     <= '0;
         body_ok_ff <= 1'b0;
      end else if (accept) begin
         phase_ff   <= phase_in;
         off_ff     <= off_in;
         body_ok_ff <= body_ok_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         net_end_ff   <= net_end_in;
         strm_end_ff  <= strm_end_in;
         edesc_end_ff <= edesc_end_in;
         nhdr_ff      <= nhdr_in;
         tag_ff       <= tag_in;
         len_ff       <= len_in;
         sid_ff       <= sid_in;
         nid_ff       <= nid_in;
      end
   end

endmodule

[hdl/nsp_back.sv]
// ----------------------------------------------------------------------------
// nsp_back
// Result sequencer: expands queued events into one or two result words.
// ----------------------------------------------------------------------------
module nsp_back
   import nsp_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  evt_type        head_evt,
   input  queue_stat_type q_stat,
   output logic           pop,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   output logic [2:0]     rsp_kind,
   output logic [7:0]     rsp_descriptor_tag,
   output logic [7:0]     rsp_descriptor_length,
   output logic [7:0]     rsp_body_byte,
   output logic [15:0]    rsp_stream_id,
   output logic [15:0]    rsp_network_id,
   output logic           rsp_last_of_run
);

   logic        valid_ff, valid_in;
   logic        pend_ff, pend_in;
   kind_type    kind_ff, kind_in;
   logic [7:0]  tag_ff, tag_in;
   logic [7:0]  len_ff, len_in;
   logic [7:0]  body_ff, body_in;
   logic [15:0] sid_ff, sid_in;
   logic [15:0] nid_ff, nid_in;
   logic        last_ff, last_in;
   logic        load, show_desc, show_ids, show_body;

   assign load = !valid_ff || rsp_ready;

   assign show_desc = (head_evt.kind == KIND_NET_HDR) || (head_evt.kind == KIND_NET_BYTE) ||
                      (head_evt.kind == KIND_STRM_HDR) || (head_evt.kind == KIND_STRM_BYTE);
   assign show_body = (head_evt.kind == KIND_NET_BYTE) || (head_evt.kind == KIND_STRM_BYTE);
   assign show_ids  = (head_evt.kind == KIND_ENTRY) || (head_evt.kind == KIND_STRM_HDR) ||
                      (head_evt.kind == KIND_STRM_BYTE);

   always_comb begin
      pop      = 1'b0;
      valid_in = valid_ff;
      pend_in  = pend_ff;
      kind_in  = kind_ff;
      tag_in   = tag_ff;
      len_in   = len_ff;
      body_in  = body_ff;
      sid_in   = sid_ff;
      nid_in   = nid_ff;
      last_in  = last_ff;
      if (load) begin
         // section end word unless a main result goes first
         valid_in = 1'b0;
         kind_in  = KIND_SECT_END;
         tag_in   = '0;
         len_in   = '0;
         body_in  = '0;
         sid_in   = '0;
         nid_in   = '0;
         last_in  = 1'b1;
         if (pend_ff) begin
            valid_in = 1'b1;
            pend_in  = 1'b0;
         end else if (!q_stat.empty) begin
            pop      = 1'b1;
            valid_in = 1'b1;
            if (head_evt.has_main) begin
               kind_in = head_evt.kind;
               tag_in  = show_desc ? head_evt.tag : 8'h00;
               len_in  = show_desc ? head_evt.len : 8'h00;
               body_in = show_body ? head_evt.body : 8'h00;
               sid_in  = show_ids ? head_evt.sid : 16'h0000;
               nid_in  = show_ids ? head_evt.nid : 16'h0000;
               last_in = !head_evt.with_end;
               pend_in = head_evt.with_end;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         pend_ff  <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
      tag_ff  <= tag_in;
      len_ff  <= len_in;
      body_ff <= body_in;
      sid_ff  <= sid_in;
      nid_ff  <= nid_in;
      last_ff <= last_in;
   end

   assign rsp_valid             = valid_ff;
   assign rsp_kind              = kind_ff;
   assign rsp_descriptor_tag    = tag_ff;
   assign rsp_descriptor_length = len_ff;
   assign rsp_body_byte         = body_ff;
   assign rsp_stream_id         = sid_ff;
   assign rsp_network_id        = nid_ff;
   assign rsp_last_of_run       = last_ff;

   a_pend_shown: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> (valid_ff && !last_ff && kind_ff != KIND_SECT_END))
      else $error("pending section end without a main word in front");

   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && kind_ff == KIND_SECT_END) |-> last_ff)
      else $error("section end word not marked last");

endmodule
